[src/rampr_pkg.sv]
// Package: types, constants and field widths for the REQ/ACK/MSG packet receiver.
package rampr_pkg;

   localparam int PAYLOAD_DEPTH = 64;
   localparam int ENTRY_BYTES   = 3;
   localparam int ENTRY_DEPTH   = PAYLOAD_DEPTH / ENTRY_BYTES;
   localparam int ENTRY_AW      = (ENTRY_DEPTH > 1) ? $clog2(ENTRY_DEPTH) : 1;
   localparam int ENTRY_CW      = $clog2(ENTRY_DEPTH + 1);
   localparam int MSG_LEN_W     = $clog2(PAYLOAD_DEPTH + 1);

   localparam int REQ_TDATA_W = 32;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_BITS    = 2 + 2 + 8 + 16 + 8 + MSG_LEN_W;
   localparam int RSP_TDATA_W = ((RSP_BITS + 7) / 8) * 8;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [15:0] SEQ_MAX     = 16'hffff;
   localparam logic [11:0] HALF_MASK   = 12'h0fff;
   localparam logic [15:0] ACK_TO_RST  = 16'd500;
   localparam logic [15:0] MSG_TO_RST  = 16'd600;

   typedef enum logic [1:0] {
      PH_LISTEN = 2'd0,
      PH_MSG    = 2'd1,
      PH_ACK    = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      FN_WORD  = 2'd0,
      FN_TICK  = 2'd1,
      FN_BEGIN = 2'd2
   } func_type;

   typedef enum logic [1:0] {
      ST_NONE    = 2'd0,
      ST_OK      = 2'd1,
      ST_ERROR   = 2'd2,
      ST_TIMEOUT = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      TX_NONE = 2'd0,
      TX_ACK  = 2'd1,
      TX_REQ  = 2'd2
   } send_kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MY_ADDRESS = 3'd0,
      CSR_REQ_TYPE   = 3'd1,
      CSR_ACK_TYPE   = 3'd2,
      CSR_MSG_TYPE   = 3'd3,
      CSR_ACK_TO     = 3'd4,
      CSR_MSG_TO     = 3'd5
   } csr_idx_type;

endpackage

[src/req_ack_msg_packet_receiver.sv]
// Top level: REQ/ACK/MSG packet receiver with timeouts and payload store.
//
//  channel | ports                      | beat contents (lowest bits first)
//  --------+----------------------------+------------------------------------------
//  input   | req_tvalid/tready/tdata/   | tdata: link_word; tuser: func
//          | tuser                      |
//  result  | rsp_tvalid/tready/tdata    | status, send_kind, send_dest, send_seq,
//          |                            | peer_address, message_length, zero pad
//  config  | csr_we/csr_index/csr_wdata | six registers, write only
//
// Every input beat yields one result beat, registered the cycle after acceptance.
// One beat per cycle is sustained; the state update and the result are a single
// pass of byte-sum, compare and select logic into the state and output registers.
// A stalled result holds in the output register; a new beat is taken in the same
// cycle that the held one leaves. Synchronous reset clears control state and
// restores register defaults; the payload store is not cleared.
module req_ack_msg_packet_receiver (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [rampr_pkg::REQ_TDATA_W-1:0] req_tdata,   // [31:0] link_word
   input  logic [rampr_pkg::REQ_TUSER_W-1:0] req_tuser,   // [1:0] func
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // status, send_kind, send_dest, send_seq, peer_address, message_length, pad
   output logic [rampr_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                              csr_we,
   input  logic [rampr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rampr_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import rampr_pkg::*;

   // configuration
   logic [7:0]  my_address_ff, req_type_ff, ack_type_ff, msg_type_ff;
   logic [15:0] ack_to_ff, msg_to_ff;

   // receiver state
   phase_type            phase_ff, phase_in;
   logic                 pending_ff, pending_in;
   logic [31:0]          first_word_ff, first_word_in;
   logic                 toggle_ff, toggle_in;
   logic [11:0]          first_half_ff, first_half_in;
   logic [MSG_LEN_W-1:0] widx_ff, widx_in;
   logic [ENTRY_CW-1:0]  entry_cnt_ff, entry_cnt_in;
   logic [15:0]          last_seq_ff, last_seq_in;
   logic [7:0]           requester_ff, requester_in;
   logic [7:0]           acknowledger_ff, acknowledger_in;
   logic [15:0]          elapsed_ff, elapsed_in;

   // payload store, one row per rebuilt 3-byte entry
   logic [23:0] store [ENTRY_DEPTH];
   logic        store_we;
   logic [23:0] store_wdata;

   // result register
   logic                 rsp_valid_ff;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   status_type    status;
   send_kind_type kind;
   logic [7:0]    dest, peer;
   logic [15:0]   seq;

   logic        req_fire;
   func_type    func;
   logic [31:0] word;
   logic [7:0]  b0, b1, b2, b3, b4, b5, b6, b7;
   logic [10:0] sum;
   logic        sum_ok;
   logic [15:0] pkt_seq;
   logic [11:0] half;
   logic [7:0]  e0;
   logic [15:0] elapsed_inc;
   logic [15:0] limit;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;
   assign func       = func_type'(req_tuser);
   assign word       = req_tdata;

   // packet bytes, most significant first
   assign b0 = first_word_ff[31:24];
   assign b1 = first_word_ff[23:16];
   assign b2 = first_word_ff[15:8];
   assign b3 = first_word_ff[7:0];
   assign b4 = word[31:24];
   assign b5 = word[23:16];
   assign b6 = word[15:8];
   assign b7 = word[7:0];

   assign sum = ((11'(b0) + 11'(b1)) + (11'(b2) + 11'(b3)))
              + ((11'(b4) + 11'(b5)) + (11'(b6) + 11'(b7)));
   assign sum_ok  = (sum[7:0] == 8'd0);
   assign pkt_seq = {b1, b2};
   assign half    = word[19:8] & HALF_MASK;
   assign e0      = first_half_ff[11:4];
   assign store_wdata = {half[7:0], first_half_ff[3:0], half[11:8], e0};
   assign elapsed_inc = (elapsed_ff != SEQ_MAX) ? (elapsed_ff + 16'd1) : elapsed_ff;
   assign limit       = (phase_ff == PH_MSG) ? msg_to_ff : ack_to_ff;

   always_comb begin
      phase_in        = phase_ff;
      pending_in      = pending_ff;
      first_word_in   = first_word_ff;
      toggle_in       = toggle_ff;
      first_half_in   = first_half_ff;
      widx_in         = widx_ff;
      entry_cnt_in    = entry_cnt_ff;
      last_seq_in     = last_seq_ff;
      requester_in    = requester_ff;
      acknowledger_in = acknowledger_ff;
      elapsed_in      = elapsed_ff;
      store_we        = 1'b0;
      status          = ST_NONE;
      kind            = TX_NONE;
      dest            = 8'd0;
      seq             = 16'd0;
      peer            = 8'd0;

      case (func)
         FN_WORD: begin
            if (!pending_ff) begin
               first_word_in = word;
               pending_in    = 1'b1;
            end else begin
               pending_in = 1'b0;
               case (phase_ff)
                  PH_MSG: begin
                     if (!(sum_ok && b4 == my_address_ff && b0 == msg_type_ff
                           && b3 == requester_ff)) begin
                        status     = ST_ERROR;
                        phase_in   = PH_LISTEN;
                        elapsed_in = 16'd0;
                     end else begin
                        last_seq_in = pkt_seq;
                        if (!toggle_ff) begin
                           first_half_in = half;
                           toggle_in     = 1'b1;
                        end else begin
                           toggle_in = 1'b0;
                           if (entry_cnt_ff == ENTRY_CW'(ENTRY_DEPTH)) begin
                              // entry does not fit: drop it
                              status     = ST_ERROR;
                              phase_in   = PH_LISTEN;
                              elapsed_in = 16'd0;
                           end else begin
                              store_we     = 1'b1;
                              widx_in      = widx_ff + MSG_LEN_W'(ENTRY_BYTES);
                              entry_cnt_in = entry_cnt_ff + ENTRY_CW'(1);
                              if (e0 == 8'd0) begin
                                 status     = ST_OK;
                                 phase_in   = PH_LISTEN;
                                 elapsed_in = 16'd0;
                              end
                           end
                        end
                     end
                  end
                  PH_ACK: begin
                     if (sum_ok && b4 == my_address_ff && b0 == ack_type_ff) begin
                        acknowledger_in = b3;
                        last_seq_in     = pkt_seq;
                        peer            = b3;
                        status          = ST_OK;
                        phase_in        = PH_LISTEN;
                        elapsed_in      = 16'd0;
                     end
                  end
                  default: begin
                     if (sum_ok && b4 == 8'd0 && b0 == req_type_ff) begin
                        requester_in  = b3;
                        last_seq_in   = pkt_seq;
                        peer          = b3;
                        kind          = TX_ACK;
                        dest          = b3;
                        seq           = pkt_seq + 16'd1;
                        widx_in       = '0;
                        entry_cnt_in  = '0;
                        toggle_in     = 1'b0;
                        first_half_in = 12'd0;
                        phase_in      = PH_MSG;
                        elapsed_in    = 16'd0;
                     end
                  end
               endcase
            end
         end
         FN_TICK: begin
            if (phase_ff == PH_MSG || phase_ff == PH_ACK) begin
               if (elapsed_inc >= limit) begin
                  status     = ST_TIMEOUT;
                  phase_in   = PH_LISTEN;
                  pending_in = 1'b0;
                  elapsed_in = 16'd0;
               end else begin
                  elapsed_in = elapsed_inc;
               end
            end
         end
         FN_BEGIN: begin
            if (phase_ff == PH_MSG || phase_ff == PH_ACK) begin
               status = ST_ERROR;
            end else begin
               kind       = TX_REQ;
               seq        = last_seq_ff + 16'd1;
               phase_in   = PH_ACK;
               pending_in = 1'b0;
               elapsed_in = 16'd0;
            end
         end
         default: begin
         end
      endcase

      rsp_data_in = RSP_TDATA_W'({widx_in, peer, seq, dest, kind, status});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         my_address_ff <= 8'd1;
         req_type_ff   <= 8'd1;
         ack_type_ff   <= 8'd2;
         msg_type_ff   <= 8'd3;
         ack_to_ff     <= ACK_TO_RST;
         msg_to_ff     <= MSG_TO_RST;
      end else if (csr_we) begin
         case (csr_idx_type'(csr_index))
            CSR_MY_ADDRESS: my_address_ff <= csr_wdata[7:0];
            CSR_REQ_TYPE:   req_type_ff   <= csr_wdata[7:0];
            CSR_ACK_TYPE:   ack_type_ff   <= csr_wdata[7:0];
            CSR_MSG_TYPE:   msg_type_ff   <= csr_wdata[7:0];
            CSR_ACK_TO:     ack_to_ff     <= csr_wdata;
            CSR_MSG_TO:     msg_to_ff     <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_LISTEN;
         pending_ff      <= 1'b0;
         first_word_ff   <= 32'd0;
         toggle_ff       <= 1'b0;
         first_half_ff   <= 12'd0;
         widx_ff         <= '0;
         entry_cnt_ff    <= '0;
         last_seq_ff     <= 16'd0;
         requester_ff    <= 8'd0;
         acknowledger_ff <= 8'd0;
         elapsed_ff      <= 16'd0;
      end else if (req_fire) begin
         phase_ff        <= phase_in;
         pending_ff      <= pending_in;
         first_word_ff   <= first_word_in;
         toggle_ff       <= toggle_in;
         first_half_ff   <= first_half_in;
         widx_ff         <= widx_in;
         entry_cnt_ff    <= entry_cnt_in;
         last_seq_ff     <= last_seq_in;
         requester_ff    <= requester_in;
         acknowledger_ff <= acknowledger_in;
         elapsed_ff      <= elapsed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && store_we) begin
         store[entry_cnt_ff[ENTRY_AW-1:0]] <= store_wdata;
      end
   end

   // output register: advance on accept, hold while stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

[tb/tb_req_ack_msg_packet_receiver.sv]
// Testbench for the REQ/ACK/MSG packet receiver: stream stimulus, local prediction, beat checks.
`timescale 1ns / 100ps

module tb_req_ack_msg_packet_receiver;
   import rampr_pkg::*;

   typedef struct {
      logic [1:0]  fn;
      logic [31:0] word;
   } link_beat_type;

   typedef struct {
      status_type            status;
      send_kind_type         kind;
      logic [7:0]            dest;
      logic [15:0]           seq;
      logic [7:0]            peer;
      logic [MSG_LEN_W-1:0]  mlen;
   } rsp_fields_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;   // [31:0] link_word
   logic [REQ_TUSER_W-1:0] req_tuser = '0;   // [1:0] func
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // [1:0] status, [3:2] send_kind, [11:4] send_dest, [27:12] send_seq,
   // [35:28] peer_address, [42:36] message_length, rest zero
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   req_ack_msg_packet_receiver uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // register copies
   logic [7:0]  c_addr  = 8'd1;
   logic [7:0]  c_req   = 8'd1;
   logic [7:0]  c_ack   = 8'd2;
   logic [7:0]  c_msg   = 8'd3;
   logic [15:0] c_ackto = ACK_TO_RST;
   logic [15:0] c_msgto = MSG_TO_RST;

   // receiver state copy
   phase_type            rx_phase   = PH_LISTEN;
   logic                 rx_pend    = 1'b0;
   logic [31:0]          rx_fword   = '0;
   logic                 rx_htog    = 1'b0;
   logic [11:0]          rx_fhalf   = '0;
   logic [MSG_LEN_W-1:0] rx_widx    = '0;
   logic [15:0]          rx_lseq    = '0;
   logic [7:0]           rx_reqr    = '0;
   logic [7:0]           rx_ackr    = '0;
   logic [15:0]          rx_elapsed = '0;

   link_beat_type  link_beats[$];
   rsp_fields_type rsp_expected[$];
   rsp_fields_type rsp_want;

   bit beat_done = 1'b0;
   bit idle_on   = 1'b1;
   int gap_left   = 0;
   int stall_left = 0;

   int n_pushed = 0;
   int n_rsp    = 0;
   int n_ok     = 0;
   int n_err    = 0;
   int n_tmo    = 0;
   int n_ack_tx = 0;
   int n_req_tx = 0;
   int n_fail   = 0;

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic void enter_phase(phase_type p);
      rx_phase   = p;
      rx_pend    = 1'b0;
      rx_elapsed = '0;
   endfunction

   function automatic rsp_fields_type predict_rsp(logic [1:0] fn, logic [31:0] w);
      rsp_fields_type r;
      logic [7:0]  b[8];
      logic [7:0]  sum;
      logic [11:0] half;
      logic [15:0] lim;
      r.status = ST_NONE;
      r.kind   = TX_NONE;
      r.dest   = '0;
      r.seq    = '0;
      r.peer   = '0;
      case (fn)
         FN_WORD: begin
            if (!rx_pend) begin
               rx_fword = w;
               rx_pend  = 1'b1;
            end else begin
               sum = '0;
               for (int i = 0; i < 4; i++) begin
                  b[i]     = rx_fword[31-8*i -: 8];
                  b[4 + i] = w[31-8*i -: 8];
               end
               for (int i = 0; i < 8; i++) sum = sum + b[i];
               rx_pend = 1'b0;
               if (rx_phase == PH_MSG) begin
                  if (sum != 8'h00 || b[4] != c_addr || b[0] != c_msg || b[3] != rx_reqr) begin
                     r.status = ST_ERROR;
                     enter_phase(PH_LISTEN);
                  end else begin
                     rx_lseq = {b[1], b[2]};
                     half    = w[19:8];
                     if (!rx_htog) begin
                        rx_fhalf = half;
                        rx_htog  = 1'b1;
                     end else begin
                        rx_htog = 1'b0;
                        // entry does not fit: drop it and abort the message
                        if (int'(rx_widx) + ENTRY_BYTES > PAYLOAD_DEPTH) begin
                           r.status = ST_ERROR;
                           enter_phase(PH_LISTEN);
                        end else begin
                           rx_widx = rx_widx + MSG_LEN_W'(ENTRY_BYTES);
                           if (rx_fhalf[11:4] == 8'h00) begin
                              r.status = ST_OK;
                              enter_phase(PH_LISTEN);
                           end
                        end
                     end
                  end
               end else if (rx_phase == PH_ACK) begin
                  if (sum == 8'h00 && b[4] == c_addr && b[0] == c_ack) begin
                     rx_ackr  = b[3];
                     rx_lseq  = {b[1], b[2]};
                     r.peer   = rx_ackr;
                     r.status = ST_OK;
                     enter_phase(PH_LISTEN);
                  end
               end else begin
                  if (sum == 8'h00 && b[4] == 8'h00 && b[0] == c_req) begin
                     rx_reqr  = b[3];
                     rx_lseq  = {b[1], b[2]};
                     r.peer   = rx_reqr;
                     r.kind   = TX_ACK;
                     r.dest   = rx_reqr;
                     r.seq    = rx_lseq + 16'd1;
                     rx_widx  = '0;
                     rx_htog  = 1'b0;
                     rx_fhalf = '0;
                     enter_phase(PH_MSG);
                  end
               end
            end
         end
         FN_TICK: begin
            if (rx_phase == PH_MSG || rx_phase == PH_ACK) begin
               lim = (rx_phase == PH_MSG) ? c_msgto : c_ackto;
               if (rx_elapsed != SEQ_MAX) rx_elapsed = rx_elapsed + 16'd1;
               if (rx_elapsed >= lim) begin
                  r.status = ST_TIMEOUT;
                  enter_phase(PH_LISTEN);
               end
            end
         end
         FN_BEGIN: begin
            if (rx_phase == PH_MSG || rx_phase == PH_ACK) begin
               r.status = ST_ERROR;
            end else begin
               r.kind = TX_REQ;
               r.seq  = rx_lseq + 16'd1;
               enter_phase(PH_ACK);
            end
         end
         default: ;
      endcase
      r.mlen = rx_widx;
      return r;
   endfunction

   function automatic int rand_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   task automatic check_field(input string fname, input logic [15:0] want_v,
                              input logic [15:0] got_v);
      if (want_v !== got_v) begin
         if (n_fail < 50)
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want_v, got_v);
         n_fail++;
      end
   endtask

   task automatic push_item(input logic [1:0] fn, input logic [31:0] w);
      link_beats.push_back('{fn, w});
      n_pushed++;
   endtask

   // Build one 8-byte packet with a zero-sum check byte; corrupt alters a header byte, the check byte, or both.
   task automatic push_packet(input logic [7:0] t, input logic [15:0] sq, input logic [7:0] src,
                              input logic [7:0] dst, input logic [11:0] half, input bit corrupt);
      logic [7:0] b5, b6, b7, flip;
      logic [3:0] junk;
      bit         hdr;
      junk = 4'($urandom);
      flip = 8'($urandom_range(1, 255));
      hdr  = 1'b0;
      b5 = {junk, half[11:8]};
      b6 = half[7:0];
      if (corrupt) begin
         case ($urandom_range(0, 3))
            0: ;
            1: begin t   = t ^ flip;   hdr = 1'b1; end
            2: begin dst = dst ^ flip; hdr = 1'b1; end
            default: begin src = src ^ flip; hdr = 1'b1; end
         endcase
      end
      b7 = 8'h00 - (t + sq[15:8] + sq[7:0] + src + dst + b5 + b6);
      // without a changed header byte always break the sum; with one, break it half the time
      if (corrupt && (!hdr || ($urandom_range(0, 1) == 0))) b7 = b7 + flip;
      push_item(FN_WORD, {t, sq, src});
      push_item(FN_WORD, {dst, b5, b6, b7});
   endtask

   task automatic wait_idle();
      while (link_beats.size() != 0 || rsp_expected.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic set_csr(input csr_idx_type idx, input logic [15:0] v);
      logic [7:0] junk;
      junk = 8'($urandom);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = (idx == CSR_ACK_TO || idx == CSR_MSG_TO) ? v : {junk, v[7:0]};
      @(negedge clock);
      csr_we = 1'b0;
      case (idx)
         CSR_MY_ADDRESS: c_addr  = v[7:0];
         CSR_REQ_TYPE:   c_req   = v[7:0];
         CSR_ACK_TYPE:   c_ack   = v[7:0];
         CSR_MSG_TYPE:   c_msg   = v[7:0];
         CSR_ACK_TO:     c_ackto = v;
         CSR_MSG_TO:     c_msgto = v;
         default: ;
      endcase
   endtask

   task automatic apply_setting(input logic [7:0] addr, input logic [7:0] rq,
                                input logic [7:0] ak, input logic [7:0] mg,
                                input logic [15:0] ato, input logic [15:0] mto);
      wait_idle();
      set_csr(CSR_MY_ADDRESS, {8'h00, addr});
      set_csr(CSR_REQ_TYPE,   {8'h00, rq});
      set_csr(CSR_ACK_TYPE,   {8'h00, ak});
      set_csr(CSR_MSG_TYPE,   {8'h00, mg});
      set_csr(CSR_ACK_TO,     ato);
      set_csr(CSR_MSG_TO,     mto);
   endtask

   task automatic run_random(input int n_target);
      int         r, n_ent, bad_at, stop_at, mid_at;
      bit         term, paused;
      logic [7:0]  src;
      logic [15:0] sq;
      logic [11:0] h1, h2;
      stop_at = n_pushed + n_target;
      mid_at  = n_pushed + n_target / 2;
      paused  = 1'b0;
      while (n_pushed < stop_at) begin
         idle_on = ($urandom_range(0, 5) != 0);
         if (!paused && n_pushed >= mid_at) begin
            // hold the sender until the receiver has caught up
            wait_idle();
            paused = 1'b1;
         end
         r = $urandom_range(0, 99);
         if (r < 35) begin
            src    = 8'($urandom);
            sq     = 16'($urandom);
            n_ent  = ($urandom_range(0, 11) == 0) ? 22 : $urandom_range(0, 6);
            term   = ($urandom_range(0, 4) != 0);
            bad_at = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2 * n_ent) : -1;
            push_packet(c_req, sq, src, 8'h00, 12'($urandom), bad_at == 0);
            for (int i = 0; i < n_ent; i++) begin
               h1 = 12'($urandom);
               h2 = 12'($urandom);
               if (term && i == n_ent - 1) h1[11:4] = 8'h00;
               else if (h1[11:4] == 8'h00) h1[11:4] = 8'h5a;
               if ($urandom_range(0, 7) == 0)
                  repeat ($urandom_range(1, 3)) push_item(FN_TICK, $urandom);
               sq = sq + 16'd1;
               push_packet(c_msg, sq, src, c_addr, h1, bad_at == 2 * i + 1);
               sq = sq + 16'd1;
               push_packet(c_msg, sq, src, c_addr, h2, bad_at == 2 * i + 2);
            end
         end else if (r < 60) begin
            src = 8'($urandom);
            sq  = 16'($urandom);
            push_item(FN_BEGIN, $urandom);
            repeat ($urandom_range(0, 2)) begin
               case ($urandom_range(0, 3))
                  0: push_packet(c_ack, sq, src, c_addr, 12'($urandom), 1'b1);
                  1: push_item(FN_TICK, $urandom);
                  2: push_item(FN_BEGIN, $urandom);
                  default: push_packet(c_req, sq, src, 8'h00, 12'($urandom), 1'b0);
               endcase
            end
            if ($urandom_range(0, 4) != 0)
               push_packet(c_ack, sq, src, c_addr, 12'($urandom), 1'b0);
         end else if (r < 75) begin
            repeat ($urandom_range(1, 12)) push_item(FN_TICK, $urandom);
         end else if (r < 85) begin
            // one or two lone words; an odd count shifts the pairing
            repeat ($urandom_range(1, 2)) push_item(FN_WORD, $urandom);
         end else begin
            push_item(2'($urandom_range(0, 3)), $urandom);
         end
      end
   endtask

   // sender
   always @(negedge clock) begin
      if (!(req_tvalid && !beat_done)) begin
         if (beat_done) begin
            beat_done = 1'b0;
            gap_left  = idle_on ? rand_gap() : 0;
         end
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (link_beats.size() > 0) begin
            req_tvalid <= 1'b1;
            req_tdata  <= link_beats[0].word;
            req_tuser  <= link_beats[0].fn;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver back-pressure
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if (idle_on && $urandom_range(0, 3) == 0) stall_left = rand_gap();
      end
   end

   // predict on every accepted input beat
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         rsp_expected.push_back(predict_rsp(req_tuser, req_tdata));
         void'(link_beats.pop_front());
         beat_done = 1'b1;
      end
   end

   // compare every accepted result beat
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (rsp_expected.size() == 0) begin
            $display("%0t: result beat with nothing expected, expected none, actual %h",
                     $time, rsp_tdata);
            n_fail++;
         end else begin
            rsp_want = rsp_expected.pop_front();
            n_rsp++;
            check_field("status",         16'(rsp_want.status), 16'(rsp_tdata[1:0]));
            check_field("send_kind",      16'(rsp_want.kind),   16'(rsp_tdata[3:2]));
            check_field("send_dest",      16'(rsp_want.dest),   16'(rsp_tdata[11:4]));
            check_field("send_seq",       rsp_want.seq,         rsp_tdata[27:12]);
            check_field("peer_address",   16'(rsp_want.peer),   16'(rsp_tdata[35:28]));
            check_field("message_length", 16'(rsp_want.mlen),
                        16'(rsp_tdata[36 +: MSG_LEN_W]));
            if (rsp_want.status == ST_OK) n_ok++;
            if (rsp_want.status == ST_ERROR) n_err++;
            if (rsp_want.status == ST_TIMEOUT) n_tmo++;
            if (rsp_want.kind == TX_ACK) n_ack_tx++;
            if (rsp_want.kind == TX_REQ) n_req_tx++;
         end
      end
   end

   initial begin
      #5000000;
      $display("FAILED: results differ");
      $finish;
   end

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: unused func, idle tick, transfer and its wrap, REQ/MSG paths
      push_item(2'b11, 32'hffff_ffff);
      push_item(FN_TICK, 32'h0000_0000);
      push_item(FN_BEGIN, 32'h0000_0000);
      push_item(FN_BEGIN, 32'hffff_ffff);
      push_packet(c_ack, 16'h1234, 8'h22, c_addr, 12'h000, 1'b1);
      push_packet(c_ack, 16'hffff, 8'hff, c_addr, 12'hfff, 1'b0);
      push_item(FN_BEGIN, 32'h0000_0000);
      push_packet(c_ack, 16'h0000, 8'h00, c_addr, 12'h000, 1'b0);
      push_packet(c_req, 16'h0000, 8'h80, 8'h00, 12'h5a5, 1'b0);
      push_packet(c_msg, 16'h0001, 8'h80, c_addr, 12'h005, 1'b0);
      push_packet(c_msg, 16'h0002, 8'h80, c_addr, 12'habc, 1'b0);
      push_packet(c_req, 16'hfffe, 8'h7f, 8'h00, 12'h000, 1'b0);
      push_item(FN_BEGIN, 32'h0000_0000);
      push_packet(c_msg, 16'h0003, 8'h11, c_addr, 12'h123, 1'b0);

      run_random(150);
      apply_setting(8'hff, 8'h00, 8'hff, 8'h80, 16'd1, 16'd2);
      run_random(120);
      apply_setting(8'h00, 8'hff, 8'h00, 8'h00, 16'hffff, 16'hffff);
      run_random(120);
      apply_setting(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                    16'($urandom_range(2, 20)), 16'($urandom_range(3, 30)));
      run_random(130);
      apply_setting(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                    16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)));
      run_random(130);

      while (link_beats.size() != 0 || rsp_expected.size() != 0) @(negedge clock);
      repeat (8) @(posedge clock);
      if (rsp_expected.size() != 0) n_fail++;

      $display("Covered %0d input beats over five register settings, %0d results checked.",
               n_pushed, n_rsp);
      $display("Outcomes: %0d success, %0d error, %0d timeout; %0d ACK and %0d REQ sends.",
               n_ok, n_err, n_tmo, n_ack_tx, n_req_tx);
      if (n_fail == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
